>>> sv/prqs_pkg.sv
// Shared types and constants of the priority ready queue scheduler.
package prqs_pkg;

    localparam int TASKS_DEF  = 16;
    localparam int LEVELS_DEF = 8;

    // Port field widths.
    localparam int FUNC_W = 2;
    localparam int ID_W   = 4;
    localparam int PRIO_W = 3;

    // Widest values the parameters may reach (256 tasks, 64 levels).
    localparam int TID_MAX_W = 8;
    localparam int LVL_MAX_W = 6;
    localparam int CNT_MAX_W = 9;

    typedef enum logic [FUNC_W-1:0] {
        FN_ADD   = 2'd0,
        FN_DEQ   = 2'd1,
        FN_REM   = 2'd2,
        FN_SCHED = 2'd3
    } func_t;

    // Broadcast from the sequencer to every level cell.
    typedef struct packed {
        logic                 upd;
        logic [LVL_MAX_W-1:0] lvl;
        logic                 set_head;
        logic [TID_MAX_W-1:0] head;
        logic                 set_tail;
        logic [TID_MAX_W-1:0] tail;
        logic                 inc;
        logic                 dec;
        logic                 scan_start;
        logic [LVL_MAX_W-1:0] scan_lvl;
    } cell_cmd_t;

    // What one level cell reports.
    typedef struct packed {
        logic [TID_MAX_W-1:0] head;
        logic [TID_MAX_W-1:0] tail;
        logic [CNT_MAX_W-1:0] count;
        logic                 nonempty;
        logic                 tok_out;
        logic                 hit;
    } cell_status_t;

endpackage

>>> sv/prqs_if.sv
// Request and response channel interfaces of the scheduler.
interface prqs_req_if;
    logic                          valid;
    logic                          ready;
    logic [prqs_pkg::FUNC_W-1:0]   func;
    logic [prqs_pkg::ID_W-1:0]     task_id;
    logic [prqs_pkg::PRIO_W-1:0]   priority_req;

    modport source (output valid, output func, output task_id, output priority_req,
                    input ready);
    modport sink   (input valid, input func, input task_id, input priority_req,
                    output ready);
endinterface

interface prqs_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [prqs_pkg::ID_W-1:0]     out_task;
    logic                          found;
    logic [prqs_pkg::ID_W-1:0]     active_task;
    logic [prqs_pkg::PRIO_W-1:0]   current_level;
    logic                          none_ready;

    modport source (output valid, output out_task, output found, output active_task,
                    output current_level, output none_ready, input ready);
    modport sink   (input valid, input out_task, input found, input active_task,
                    input current_level, input none_ready, output ready);
endinterface

>>> sv/prqs_level_cell.sv
// One priority level: queue head, tail and count, plus one stage of the scan chain.
module prqs_level_cell #(
    parameter int TASKS    = prqs_pkg::TASKS_DEF,
    parameter int LEVELS   = prqs_pkg::LEVELS_DEF,
    parameter int LEVEL_ID = 0
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  prqs_pkg::cell_cmd_t    cmd,
    input  logic                   tok_in,
    output prqs_pkg::cell_status_t status
);

    localparam int TW = $clog2(TASKS);
    localparam int CW = $clog2(TASKS + 1);
    localparam logic IS_LAST = (LEVEL_ID == LEVELS - 1);

    logic [TW-1:0] head_reg;
    logic [TW-1:0] tail_reg;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic          tok_reg;
    logic          tok_next;
    logic          mine;
    logic          start_here;
    logic          nonempty;

    assign mine       = cmd.upd &&
                        (cmd.lvl == prqs_pkg::LVL_MAX_W'(LEVEL_ID));
    assign start_here = cmd.scan_start &&
                        (cmd.scan_lvl == prqs_pkg::LVL_MAX_W'(LEVEL_ID));
    assign nonempty   = (count_reg != '0);

    always_comb
    begin
        count_next = count_reg;
        if (mine && cmd.inc)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (mine && cmd.dec)
        begin
            count_next = count_reg - CW'(1);
        end
        // token stops at a non-empty level or at the idle level
        tok_next = start_here || tok_in;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            tok_reg   <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            tok_reg   <= tok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mine && cmd.set_head)
        begin
            head_reg <= TW'(cmd.head);
        end
        if (mine && cmd.set_tail)
        begin
            tail_reg <= TW'(cmd.tail);
        end
    end

    assign status.head     = prqs_pkg::TID_MAX_W'(head_reg);
    assign status.tail     = prqs_pkg::TID_MAX_W'(tail_reg);
    assign status.count    = prqs_pkg::CNT_MAX_W'(count_reg);
    assign status.nonempty = nonempty;
    assign status.tok_out  = tok_reg && !nonempty && !IS_LAST;
    assign status.hit      = tok_reg && (nonempty || IS_LAST);

endmodule

>>> sv/priority_ready_queue_scheduler.sv
// Top level of the priority ready queue scheduler: sequencer, link memory, level cells.
//
// One ready queue per priority level (0 most urgent, LEVELS-1 the idle level),
// each a singly linked FIFO whose links sit in one shared link memory of TASKS
// entries; each level keeps head, tail and count in a level cell. Items are taken
// one at a time and each gives exactly one response word. An add completes in the
// execute state; a dequeue or removal of a queue head reads the head's link and
// then pops; removal of a later entry walks the list and, when the entry is not
// the tail, bridges over it in an unlink step; a dequeue or removal that finds its
// level empty, or misses in a one-entry level, goes straight to the response.
// Removal walks the list one link per cycle through the registered read port of
// the link memory; schedule passes a token down the chain of level cells, one
// cell per cycle, stopping at the first non-empty level or at the idle level.
// A finished response waits in an output register, so a new request word is taken
// while the previous response is still pending; the item after that waits in its
// done state until the sink takes the word. Link entries never written read back
// as arbitrary values, but the walks are bounded by the level counts and never
// reach them. No clearing pass is needed.
module priority_ready_queue_scheduler #(
    parameter int TASKS  = prqs_pkg::TASKS_DEF,
    parameter int LEVELS = prqs_pkg::LEVELS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    prqs_req_if.sink    req,
    prqs_rsp_if.source  rsp
);

    localparam int TW = $clog2(TASKS);
    localparam int LW = $clog2(LEVELS);
    localparam int CW = $clog2(TASKS + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_POP,
        S_WALK,
        S_UNLINK,
        S_SCAN,
        S_DONE
    } state_t;

    // sequencer registers
    state_t                     state_reg, state_next;
    prqs_pkg::func_t            func_reg, func_next;
    logic [prqs_pkg::ID_W-1:0]  tid_reg, tid_next;
    logic                       tid_ok_reg, tid_ok_next;
    logic [LW-1:0]              lvl_reg, lvl_next;
    logic [TW-1:0]              prev_reg, prev_next;
    logic [TW-1:0]              cur_reg, cur_next;
    logic [CW-1:0]              idx_reg, idx_next;
    logic [TW-1:0]              res_task_reg, res_task_next;
    logic                       res_found_reg, res_found_next;
    logic                       res_none_reg, res_none_next;
    logic [LW-1:0]              level_now_reg, level_now_next;
    logic [TW-1:0]              task_now_reg, task_now_next;

    // response word register
    logic                       rsp_valid_reg, rsp_valid_next;
    logic [prqs_pkg::ID_W-1:0]  out_task_reg, out_task_next;
    logic                       found_reg, found_next;
    logic [prqs_pkg::ID_W-1:0]  active_task_reg, active_task_next;
    logic [prqs_pkg::PRIO_W-1:0] current_level_reg, current_level_next;
    logic                       none_ready_reg, none_ready_next;

    // link memory
    logic [TW-1:0]              link_mem [TASKS];
    logic [TW-1:0]              rd_data_reg;
    logic [TW-1:0]              rd_addr;
    logic                       lk_we;
    logic [TW-1:0]              lk_waddr;
    logic [TW-1:0]              lk_wdata;

    // level cells
    prqs_pkg::cell_cmd_t        cmd;
    prqs_pkg::cell_status_t     cell_st [LEVELS];
    logic [LEVELS-1:0]          cell_tok_in;

    // decoded views
    logic [LW-1:0]              req_lvl;
    logic                       req_tid_ok;
    logic [TW-1:0]              tid_idx;
    logic [CW-1:0]              sel_cnt;
    logic [TW-1:0]              sel_head;
    logic [TW-1:0]              sel_tail;
    logic                       any_hit;
    logic [LW-1:0]              hit_lvl;
    logic [TW-1:0]              hit_head;
    logic                       hit_nonempty;

    // out-of-range level maps to the idle level
    assign req_lvl    = (int'(req.priority_req) >= LEVELS) ? LW'(LEVELS - 1)
                                                           : LW'(req.priority_req);
    assign req_tid_ok = (int'(req.task_id) < TASKS);
    assign tid_idx    = TW'(tid_reg);

    assign sel_cnt  = CW'(cell_st[lvl_reg].count);
    assign sel_head = TW'(cell_st[lvl_reg].head);
    assign sel_tail = TW'(cell_st[lvl_reg].tail);

    // one-hot token hit to level index
    always_comb
    begin
        any_hit      = 1'b0;
        hit_lvl      = '0;
        hit_head     = '0;
        hit_nonempty = 1'b0;
        for (int i = 0; i < LEVELS; i++)
        begin
            if (cell_st[i].hit)
            begin
                any_hit      = 1'b1;
                hit_lvl      = hit_lvl | LW'(i);
                hit_head     = hit_head | TW'(cell_st[i].head);
                hit_nonempty = hit_nonempty | cell_st[i].nonempty;
            end
        end
    end

    always_comb
    begin
        state_next         = state_reg;
        func_next          = func_reg;
        tid_next           = tid_reg;
        tid_ok_next        = tid_ok_reg;
        lvl_next           = lvl_reg;
        prev_next          = prev_reg;
        cur_next           = cur_reg;
        idx_next           = idx_reg;
        res_task_next      = res_task_reg;
        res_found_next     = res_found_reg;
        res_none_next      = res_none_reg;
        level_now_next     = level_now_reg;
        task_now_next      = task_now_reg;
        rsp_valid_next     = rsp_valid_reg && !rsp.ready;
        out_task_next      = out_task_reg;
        found_next         = found_reg;
        active_task_next   = active_task_reg;
        current_level_next = current_level_reg;
        none_ready_next    = none_ready_reg;

        cmd        = '0;
        cmd.lvl    = prqs_pkg::LVL_MAX_W'(lvl_reg);
        rd_addr    = '0;
        lk_we      = 1'b0;
        lk_waddr   = '0;
        lk_wdata   = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    func_next      = prqs_pkg::func_t'(req.func);
                    tid_next       = req.task_id;
                    tid_ok_next    = req_tid_ok;
                    lvl_next       = req_lvl;
                    res_task_next  = '0;
                    res_found_next = 1'b0;
                    res_none_next  = 1'b0;
                    state_next     = S_EXEC;
                end
            end

            S_EXEC:
            begin
                state_next = S_DONE;
                unique case (func_reg)
                    prqs_pkg::FN_ADD:
                    begin
                        if (tid_ok_reg && sel_cnt != CW'(TASKS))
                        begin
                            cmd.upd      = 1'b1;
                            cmd.set_head = (sel_cnt == '0);
                            cmd.head     = prqs_pkg::TID_MAX_W'(tid_idx);
                            cmd.set_tail = 1'b1;
                            cmd.tail     = prqs_pkg::TID_MAX_W'(tid_idx);
                            cmd.inc      = 1'b1;
                            if (sel_cnt != '0)
                            begin
                                lk_we    = 1'b1;
                                lk_waddr = sel_tail;
                                lk_wdata = tid_idx;
                            end
                            if (lvl_reg < level_now_reg)
                            begin
                                level_now_next = lvl_reg;
                            end
                        end
                    end
                    prqs_pkg::FN_DEQ:
                    begin
                        if (sel_cnt != '0)
                        begin
                            rd_addr    = sel_head;
                            cur_next   = sel_head;
                            state_next = S_POP;
                        end
                    end
                    prqs_pkg::FN_REM:
                    begin
                        if (tid_ok_reg && sel_cnt != '0)
                        begin
                            rd_addr = sel_head;
                            if (sel_head == tid_idx)
                            begin
                                cur_next   = sel_head;
                                state_next = S_POP;
                            end
                            else if (sel_cnt != CW'(1))
                            begin
                                prev_next  = sel_head;
                                idx_next   = CW'(1);
                                state_next = S_WALK;
                            end
                        end
                    end
                    prqs_pkg::FN_SCHED:
                    begin
                        cmd.scan_start = 1'b1;
                        cmd.scan_lvl   = prqs_pkg::LVL_MAX_W'(level_now_reg);
                        state_next     = S_SCAN;
                    end
                    default:
                    begin
                        state_next = S_DONE;
                    end
                endcase
            end

            // head leaves: new head is the popped task's link
            S_POP:
            begin
                cmd.upd        = 1'b1;
                cmd.set_head   = 1'b1;
                cmd.head       = prqs_pkg::TID_MAX_W'(rd_data_reg);
                cmd.dec        = 1'b1;
                res_task_next  = cur_reg;
                res_found_next = 1'b1;
                state_next     = S_DONE;
            end

            // rd_data_reg holds the successor of prev_reg
            S_WALK:
            begin
                if (rd_data_reg == tid_idx)
                begin
                    res_task_next  = rd_data_reg;
                    res_found_next = 1'b1;
                    if (idx_reg == sel_cnt - CW'(1))
                    begin
                        cmd.upd      = 1'b1;
                        cmd.set_tail = 1'b1;
                        cmd.tail     = prqs_pkg::TID_MAX_W'(prev_reg);
                        cmd.dec      = 1'b1;
                        state_next   = S_DONE;
                    end
                    else
                    begin
                        rd_addr    = rd_data_reg;
                        state_next = S_UNLINK;
                    end
                end
                else
                begin
                    prev_next = rd_data_reg;
                    idx_next  = idx_reg + CW'(1);
                    if (idx_reg + CW'(1) < sel_cnt)
                    begin
                        rd_addr = rd_data_reg;
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
            end

            // bridge prev over the removed task
            S_UNLINK:
            begin
                lk_we      = 1'b1;
                lk_waddr   = prev_reg;
                lk_wdata   = rd_data_reg;
                cmd.upd    = 1'b1;
                cmd.dec    = 1'b1;
                state_next = S_DONE;
            end

            S_SCAN:
            begin
                if (any_hit)
                begin
                    level_now_next = hit_lvl;
                    if (hit_nonempty)
                    begin
                        task_now_next = hit_head;
                    end
                    else
                    begin
                        res_none_next = 1'b1;
                    end
                    state_next = S_DONE;
                end
            end

            S_DONE:
            begin
                if (!rsp_valid_reg || rsp.ready)
                begin
                    rsp_valid_next     = 1'b1;
                    out_task_next      = prqs_pkg::ID_W'(res_task_reg);
                    found_next         = res_found_reg;
                    active_task_next   = prqs_pkg::ID_W'(task_now_reg);
                    current_level_next = prqs_pkg::PRIO_W'(level_now_reg);
                    none_ready_next    = res_none_reg;
                    state_next         = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= S_IDLE;
            func_reg          <= prqs_pkg::FN_ADD;
            tid_reg           <= '0;
            tid_ok_reg        <= 1'b0;
            lvl_reg           <= '0;
            prev_reg          <= '0;
            cur_reg           <= '0;
            idx_reg           <= '0;
            res_task_reg      <= '0;
            res_found_reg     <= 1'b0;
            res_none_reg      <= 1'b0;
            level_now_reg     <= LW'(LEVELS - 1);
            task_now_reg      <= '0;
            rsp_valid_reg     <= 1'b0;
            out_task_reg      <= '0;
            found_reg         <= 1'b0;
            active_task_reg   <= '0;
            current_level_reg <= '0;
            none_ready_reg    <= 1'b0;
        end
        else
        begin
            state_reg         <= state_next;
            func_reg          <= func_next;
            tid_reg           <= tid_next;
            tid_ok_reg        <= tid_ok_next;
            lvl_reg           <= lvl_next;
            prev_reg          <= prev_next;
            cur_reg           <= cur_next;
            idx_reg           <= idx_next;
            res_task_reg      <= res_task_next;
            res_found_reg     <= res_found_next;
            res_none_reg      <= res_none_next;
            level_now_reg     <= level_now_next;
            task_now_reg      <= task_now_next;
            rsp_valid_reg     <= rsp_valid_next;
            out_task_reg      <= out_task_next;
            found_reg         <= found_next;
            active_task_reg   <= active_task_next;
            current_level_reg <= current_level_next;
            none_ready_reg    <= none_ready_next;
        end
    end

    // link memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (lk_we)
        begin
            link_mem[lk_waddr] <= lk_wdata;
        end
        rd_data_reg <= link_mem[rd_addr];
    end

    // chain of level cells; the scan token moves toward the idle level
    assign cell_tok_in[0] = 1'b0;
    for (genvar g = 1; g < LEVELS; g++)
    begin : g_tok
        assign cell_tok_in[g] = cell_st[g-1].tok_out;
    end

    for (genvar g = 0; g < LEVELS; g++)
    begin : g_cell
        prqs_level_cell #(
            .TASKS    (TASKS),
            .LEVELS   (LEVELS),
            .LEVEL_ID (g)
        ) u_cell (
            .clk    (clk),
            .rst_n  (rst_n),
            .cmd    (cmd),
            .tok_in (cell_tok_in[g]),
            .status (cell_st[g])
        );
    end

    assign req.ready         = (state_reg == S_IDLE);
    assign rsp.valid         = rsp_valid_reg;
    assign rsp.out_task      = out_task_reg;
    assign rsp.found         = found_reg;
    assign rsp.active_task   = active_task_reg;
    assign rsp.current_level = current_level_reg;
    assign rsp.none_ready    = none_ready_reg;

endmodule
